// File: hw/rtl/rrts_pkg.sv
// rrts_pkg: shared constants, types and helpers of the range rule tiling selector
// used by rrts_cell, rrts_out and range_rule_tiling_selector_top; no dependencies
package rrts_pkg;

  localparam int RULES_PER_TABLE = 16;
  localparam int NUM_TABLES      = 5;
  localparam int NUM_BOUNDS      = 6;
  localparam int NUM_SLOTS       = NUM_TABLES * RULES_PER_TABLE;

  localparam int SLOT_W     = 7;
  localparam int CAND_W     = 16;
  localparam int BOUND_W    = 32;
  localparam int SIZE_W     = 31;
  localparam int TBL_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int POS_W      = (RULES_PER_TABLE > 1) ? $clog2(RULES_PER_TABLE) : 1;
  localparam int SLOT_CMP_W = ($clog2(NUM_SLOTS + 1) > SLOT_W) ?
                              $clog2(NUM_SLOTS + 1) : SLOT_W;
  localparam int ROWS_W     = CAND_W + 1;
  localparam int TILE_W     = 9;

  localparam int IN_DATA_W  = 312;
  localparam int OUT_DATA_W = 120;
  localparam int IN_USER_W  = 2;

  // operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_INVAL = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_M_TILE_DEFAULT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_DEFAULT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_ROWS_DEFAULT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NPU_SPLIT_DEFAULT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_SPLIT_DEFAULT = 3'd4;

  // table numbers
  localparam int TBL_M_TILE    = 0;
  localparam int TBL_INTERVAL  = 1;
  localparam int TBL_TILE_ROWS = 2;
  localparam int TBL_NPU_SPLIT = 3;
  localparam int TBL_DATA_SPLIT = 4;

  // bound order inside a rule
  localparam int B_M_LO = 0;
  localparam int B_M_HI = 1;
  localparam int B_K_LO = 2;
  localparam int B_K_HI = 3;
  localparam int B_N_LO = 4;
  localparam int B_N_HI = 5;

  localparam logic [TILE_W-1:0] TILE_256 = 9'd256;
  localparam logic [TILE_W-1:0] TILE_128 = 9'd128;
  localparam logic [CAND_W-1:0] M_TILE_BIG = 16'd256;

  // query token walking down the cell chain
  typedef struct packed {
    logic [SIZE_W-1:0]                  m;
    logic [SIZE_W-1:0]                  k;
    logic [SIZE_W-1:0]                  n;
    logic [NUM_TABLES-1:0]              hit;
    logic [NUM_TABLES-1:0][CAND_W-1:0]  pick;
  } rrts_tok_pay_t;

  typedef struct packed {
    logic          vld;
    rrts_tok_pay_t pay;
  } rrts_tok_t;

  // rule update broadcast to the cells
  typedef struct packed {
    logic                               wr;
    logic                               inv;
    logic [TBL_W-1:0]                   tbl;
    logic [CAND_W-1:0]                  cand;
    logic [NUM_BOUNDS-1:0][BOUND_W-1:0] bnd;
  } rrts_rule_cmd_t;

  // all ones bound is a wildcard; other bounds compare as signed 32 bit
  function automatic logic in_range(logic [SIZE_W-1:0] v, logic [BOUND_W-1:0] lo,
                                    logic [BOUND_W-1:0] hi);
    logic lo_ok;
    logic hi_ok;
    lo_ok = (lo == '1) || ($signed({1'b0, v}) >= $signed(lo));
    hi_ok = (hi == '1) || ($signed({1'b0, v}) <= $signed(hi));
    return lo_ok && hi_ok;
  endfunction

endpackage

// File: hw/rtl/rrts_cell.sv
// rrts_cell: one priority position of all five rule tables plus one chain stage
// depends on rrts_pkg
module rrts_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    advance_i,
  input  rrts_pkg::rrts_rule_cmd_t cmd_i,
  input  rrts_pkg::rrts_tok_t     tok_i,
  output rrts_pkg::rrts_tok_t     tok_o
);
  import rrts_pkg::*;

  logic [NUM_TABLES-1:0]                               valid_q;
  logic [NUM_TABLES-1:0][CAND_W-1:0]                   cand_q;
  logic [NUM_TABLES-1:0][NUM_BOUNDS-1:0][BOUND_W-1:0]  bnd_q;

  logic          vld_q;
  rrts_tok_pay_t pay_q;
  rrts_tok_pay_t pay_d;

  // first valid matching rule wins, earlier cells already had priority
  always_comb begin
    pay_d = tok_i.pay;
    for (int t = 0; t < NUM_TABLES; t++) begin
      if (!tok_i.pay.hit[t] && valid_q[t] &&
          in_range(tok_i.pay.m, bnd_q[t][B_M_LO], bnd_q[t][B_M_HI]) &&
          in_range(tok_i.pay.k, bnd_q[t][B_K_LO], bnd_q[t][B_K_HI]) &&
          in_range(tok_i.pay.n, bnd_q[t][B_N_LO], bnd_q[t][B_N_HI])) begin
        pay_d.hit[t]  = 1'b1;
        pay_d.pick[t] = cand_q[t];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      for (int t = 0; t < NUM_TABLES; t++) begin
        if (cmd_i.tbl == TBL_W'(t)) begin
          if (cmd_i.wr) begin
            valid_q[t] <= 1'b1;
          end else if (cmd_i.inv) begin
            valid_q[t] <= 1'b0;
          end
        end
      end
      if (advance_i) begin
        vld_q <= tok_i.vld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int t = 0; t < NUM_TABLES; t++) begin
      if (cmd_i.wr && (cmd_i.tbl == TBL_W'(t))) begin
        cand_q[t] <= cmd_i.cand;
        bnd_q[t]  <= cmd_i.bnd;
      end
    end
    if (advance_i) begin
      pay_q <= pay_d;
    end
  end

  assign tok_o.vld = vld_q;
  assign tok_o.pay = pay_q;

endmodule

// File: hw/rtl/rrts_out.sv
// rrts_out: merges table defaults into the chain result and holds the output register
// depends on rrts_pkg
module rrts_out (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  rrts_pkg::rrts_tok_t                           tok_i,
  input  logic [rrts_pkg::NUM_TABLES-1:0][rrts_pkg::CAND_W-1:0] dflt_i,
  output logic                                          take_o,
  output logic                                          m_axis_tvalid_o,
  input  logic                                          m_axis_tready_i,
  output logic [rrts_pkg::OUT_DATA_W-1:0]               m_axis_tdata_o
);
  import rrts_pkg::*;

  logic                                  vld_q;
  logic [OUT_DATA_W-1:0]                 data_q;
  logic [OUT_DATA_W-1:0]                 data_d;
  logic [NUM_TABLES-1:0][CAND_W-1:0]     pick;
  logic [ROWS_W-1:0]                     rows;
  logic [TILE_W-1:0]                     n_tile;

  assign take_o = !vld_q || m_axis_tready_i;

  always_comb begin
    for (int t = 0; t < NUM_TABLES; t++) begin
      pick[t] = tok_i.pay.hit[t] ? tok_i.pay.pick[t] : dflt_i[t];
    end
    rows   = {pick[TBL_TILE_ROWS], 1'b0};
    n_tile = (pick[TBL_M_TILE] == M_TILE_BIG) ? TILE_128 : TILE_256;
    data_d = {4'b0, TILE_256, n_tile, rows, pick[TBL_DATA_SPLIT], pick[TBL_NPU_SPLIT],
              rows, pick[TBL_INTERVAL], pick[TBL_M_TILE]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take_o) begin
      vld_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && tok_i.vld) begin
      data_q <= data_d;
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = data_q;

endmodule

// File: hw/rtl/range_rule_tiling_selector_top.sv
// range_rule_tiling_selector_top: rule decode, default registers and the cell chain
// depends on rrts_pkg, rrts_cell and rrts_out
//
// Usage: software loads rules over the slave stream, one transaction per rule
// write or invalidate (tuser = operation), in priority order per table, and sets
// the five default registers over the cfg write port while the block is idle.
// A query transaction carries m, k and n; one result transaction comes back on
// the master stream with the five picks and the derived tile values.
// Rule writes and invalidates produce no result.
// A query walks a chain of RULES_PER_TABLE cells, one cell per cycle while the
// chain is not held by a full output register, each cell holding one priority
// position of all five tables; the result is registered in rrts_out after the
// last cell, and no new transaction is taken while the query is in the chain.
// Reset clears all rule valid bits, the default registers and the pipeline.
// If the receiver stalls, the result waits in the output register; the block
// still takes the next query, which holds at the chain end until the register
// frees up, and no input is taken while a query is in the chain.
module range_rule_tiling_selector_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // rule_slot, candidate, m_low, m_high, k_low, k_high, n_low, n_high,
  // m_size, k_size, n_size
  input  logic [rrts_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // operation
  input  logic [rrts_pkg::IN_USER_W-1:0]     s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // m_tile, comm_interval, comm_tile_rows, npu_split, data_split,
  // comm_block_rows, n_tile, k_tile
  output logic [rrts_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  input  logic                               cfg_we_i,
  input  logic [rrts_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rrts_pkg::CAND_W-1:0]        cfg_wdata_i
);
  import rrts_pkg::*;

  logic [NUM_TABLES-1:0][CAND_W-1:0] dflt_q;

  logic                               s_acc;
  logic [1:0]                         op;
  logic [SLOT_W-1:0]                  slot;
  logic [SLOT_CMP_W-1:0]              slot_ext;
  logic                               slot_ok;
  logic [TBL_W-1:0]                   tbl;
  logic [POS_W-1:0]                   pos;
  logic [NUM_BOUNDS-1:0][BOUND_W-1:0] bnd;

  rrts_tok_t                          tok [RULES_PER_TABLE+1];
  rrts_rule_cmd_t                     cmd [RULES_PER_TABLE];
  logic [RULES_PER_TABLE-1:0]         busy_vec;
  logic                               advance;
  logic                               take;

  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign op       = s_axis_tuser_i;
  assign slot     = s_axis_tdata_i[6:0];
  assign slot_ext = SLOT_CMP_W'(slot);
  assign slot_ok  = slot_ext < SLOT_CMP_W'(NUM_SLOTS);

  assign bnd[B_M_LO] = s_axis_tdata_i[54:23];
  assign bnd[B_M_HI] = s_axis_tdata_i[86:55];
  assign bnd[B_K_LO] = s_axis_tdata_i[118:87];
  assign bnd[B_K_HI] = s_axis_tdata_i[150:119];
  assign bnd[B_N_LO] = s_axis_tdata_i[182:151];
  assign bnd[B_N_HI] = s_axis_tdata_i[214:183];

  // split slot into table number and priority position
  always_comb begin
    tbl = '0;
    pos = POS_W'(slot_ext);
    for (int t = 1; t < NUM_TABLES; t++) begin
      if (slot_ext >= SLOT_CMP_W'(t * RULES_PER_TABLE)) begin
        tbl = TBL_W'(t);
        pos = POS_W'(slot_ext - SLOT_CMP_W'(t * RULES_PER_TABLE));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_M_TILE_DEFAULT:     dflt_q[TBL_M_TILE]     <= cfg_wdata_i;
        CFG_INTERVAL_DEFAULT:   dflt_q[TBL_INTERVAL]   <= cfg_wdata_i;
        CFG_TILE_ROWS_DEFAULT:  dflt_q[TBL_TILE_ROWS]  <= cfg_wdata_i;
        CFG_NPU_SPLIT_DEFAULT:  dflt_q[TBL_NPU_SPLIT]  <= cfg_wdata_i;
        CFG_DATA_SPLIT_DEFAULT: dflt_q[TBL_DATA_SPLIT] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // one query at a time in the chain
  assign s_axis_tready_o = !(|busy_vec);
  assign advance         = !tok[RULES_PER_TABLE].vld || take;

  assign tok[0].vld       = s_acc && (op == OP_QUERY);
  assign tok[0].pay.m     = s_axis_tdata_i[245:215];
  assign tok[0].pay.k     = s_axis_tdata_i[276:246];
  assign tok[0].pay.n     = s_axis_tdata_i[307:277];
  assign tok[0].pay.hit   = '0;
  assign tok[0].pay.pick  = '0;

  for (genvar c = 0; c < RULES_PER_TABLE; c++) begin : g_cell
    assign cmd[c].wr   = s_acc && (op == OP_WRITE) && slot_ok && (pos == POS_W'(c));
    assign cmd[c].inv  = s_acc && (op == OP_INVAL) && slot_ok && (pos == POS_W'(c));
    assign cmd[c].tbl  = tbl;
    assign cmd[c].cand = s_axis_tdata_i[22:7];
    assign cmd[c].bnd  = bnd;
    assign busy_vec[c] = tok[c+1].vld;

    rrts_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .cmd_i     (cmd[c]),
      .tok_i     (tok[c]),
      .tok_o     (tok[c+1])
    );
  end

  rrts_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tok_i           (tok[RULES_PER_TABLE]),
    .dflt_i          (dflt_q),
    .take_o          (take),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench for range_rule_tiling_selector_top; keeps its own copy
// of the five rule tables and default registers and predicts every query result
// depends on rrts_pkg and the selector RTL
module tb_top;
  import rrts_pkg::*;

  localparam logic [1:0]         OP_UNUSED      = 2'd3;
  localparam logic [BOUND_W-1:0] WILD           = 32'hFFFF_FFFF;
  localparam logic [BOUND_W-1:0] INT_MIN_B      = 32'h8000_0000;
  localparam logic [BOUND_W-1:0] INT_MAX_B      = 32'h7FFF_FFFF;
  localparam logic [SIZE_W-1:0]  SIZE_MAX       = '1;
  localparam logic [CAND_W-1:0]  BIG_M_TILE     = 16'd256;
  localparam logic [TILE_W-1:0]  TILE_FULL      = 9'd256;
  localparam logic [TILE_W-1:0]  TILE_HALF      = 9'd128;
  localparam logic [NUM_BOUNDS-1:0][BOUND_W-1:0] ALL_WILD = {NUM_BOUNDS{WILD}};
  localparam logic [NUM_TABLES-1:0][CAND_W-1:0]  CATCH_ALL_CAND =
    {16'd1234, 16'd0, 16'hFFFF, 16'hFFFF, 16'd256};
  localparam int RX_HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT      = 2000;
  localparam int RANDOM_PER_PHASE = 230;

  // one input transaction, packed so that it maps onto tdata from the low end
  typedef struct packed {
    logic [1:0]                         op;
    logic [SIZE_W-1:0]                  n;
    logic [SIZE_W-1:0]                  k;
    logic [SIZE_W-1:0]                  m;
    logic [NUM_BOUNDS-1:0][BOUND_W-1:0] bnd;
    logic [CAND_W-1:0]                  cand;
    logic [SLOT_W-1:0]                  slot;
  } request_t;

  // one result transaction, m_tile in the lowest bits
  typedef struct packed {
    logic [TILE_W-1:0]   k_tile;
    logic [TILE_W-1:0]   n_tile;
    logic [ROWS_W-1:0]   block_rows;
    logic [CAND_W-1:0]   data_split;
    logic [CAND_W-1:0]   npu_split;
    logic [ROWS_W-1:0]   tile_rows;
    logic [CAND_W-1:0]   comm_interval;
    logic [CAND_W-1:0]   m_tile;
  } tiling_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready_o;
  logic [IN_DATA_W-1:0]   s_axis_tdata;
  logic [IN_USER_W-1:0]   s_axis_tuser;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata_o;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [CAND_W-1:0]      cfg_wdata;

  // predictor state
  logic                   rule_on   [NUM_SLOTS];
  logic [CAND_W-1:0]      rule_val  [NUM_SLOTS];
  int                     rule_lim  [NUM_SLOTS][NUM_BOUNDS];
  logic [CAND_W-1:0]      dflt      [NUM_TABLES];
  tiling_t                tiling_q  [$];

  tiling_t                want_tiling;
  tiling_t                got_tiling;
  int                     fail_count;
  int                     idle_cycles;
  bit                     calm;
  bit                     rx_hold_req;

  range_rule_tiling_selector_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit bound_holds(logic [SIZE_W-1:0] v, int lo, int hi);
    longint x;
    x = longint'(v);
    return (lo == -1 || x >= lo) && (hi == -1 || x <= hi);
  endfunction

  function automatic logic [CAND_W-1:0] table_pick(int t, logic [SIZE_W-1:0] m,
                                                   logic [SIZE_W-1:0] k,
                                                   logic [SIZE_W-1:0] n);
    int s;
    for (int r = 0; r < RULES_PER_TABLE; r++) begin
      s = t * RULES_PER_TABLE + r;
      if (rule_on[s] &&
          bound_holds(m, rule_lim[s][B_M_LO], rule_lim[s][B_M_HI]) &&
          bound_holds(k, rule_lim[s][B_K_LO], rule_lim[s][B_K_HI]) &&
          bound_holds(n, rule_lim[s][B_N_LO], rule_lim[s][B_N_HI]))
        return rule_val[s];
    end
    return dflt[t];
  endfunction

  function automatic void apply_request(request_t r);
    tiling_t e;
    logic [CAND_W-1:0] p [NUM_TABLES];
    case (r.op)
      OP_WRITE: begin
        if (r.slot < NUM_SLOTS) begin
          rule_val[r.slot] = r.cand;
          for (int i = 0; i < NUM_BOUNDS; i++) rule_lim[r.slot][i] = r.bnd[i];
          rule_on[r.slot] = 1'b1;
        end
      end
      OP_INVAL: begin
        if (r.slot < NUM_SLOTS) rule_on[r.slot] = 1'b0;
      end
      OP_QUERY: begin
        for (int t = 0; t < NUM_TABLES; t++) p[t] = table_pick(t, r.m, r.k, r.n);
        e.m_tile        = p[TBL_M_TILE];
        e.comm_interval = p[TBL_INTERVAL];
        e.tile_rows     = {p[TBL_TILE_ROWS], 1'b0};
        e.npu_split     = p[TBL_NPU_SPLIT];
        e.data_split    = p[TBL_DATA_SPLIT];
        e.block_rows    = e.tile_rows;
        e.n_tile        = (p[TBL_M_TILE] == BIG_M_TILE) ? TILE_HALF : TILE_FULL;
        e.k_tile        = TILE_FULL;
        tiling_q.push_back(e);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_request(input request_t r);
    int gap;
    if (!calm && $urandom_range(99) < 38) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, r.n, r.k, r.m, r.bnd, r.cand, r.slot};
    s_axis_tuser  <= r.op;
    @(posedge clk_i);
    while (s_axis_tready_o !== 1'b1) @(posedge clk_i);
    apply_request(r);
  endtask

  // drop valid, let every expected result come back, then let the chain empty
  task automatic wait_block_idle();
    s_axis_tvalid <= 1'b0;
    while (tiling_q.size() != 0) @(posedge clk_i);
    repeat (RULES_PER_TABLE + 4) @(posedge clk_i);
  endtask

  // legal indexes first, then the unused ones, which must not alias onto them
  task automatic program_defaults(input logic [NUM_TABLES-1:0][CAND_W-1:0] vals);
    for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_IDX_W'(i);
      cfg_wdata <= (i < NUM_TABLES) ? vals[i] : 16'($urandom);
      @(posedge clk_i);
      if (i < NUM_TABLES) dflt[i] = vals[i];
    end
    cfg_we <= 1'b0;
  endtask

  function automatic request_t random_request();
    request_t r;
    r.op   = 2'($urandom_range(3));
    r.slot = SLOT_W'($urandom_range((1 << SLOT_W) - 1));
    r.cand = CAND_W'($urandom);
    for (int i = 0; i < NUM_BOUNDS; i++) r.bnd[i] = $urandom;
    r.m = SIZE_W'($urandom);
    r.k = SIZE_W'($urandom);
    r.n = SIZE_W'($urandom);
    return r;
  endfunction

  task automatic send_query(input logic [SIZE_W-1:0] m, input logic [SIZE_W-1:0] k,
                            input logic [SIZE_W-1:0] n);
    request_t r;
    r = random_request();
    r.op = OP_QUERY;
    r.m = m;
    r.k = k;
    r.n = n;
    send_request(r);
  endtask

  task automatic send_rule_op(input logic [1:0] op, input int slot,
                              input logic [CAND_W-1:0] cand,
                              input logic [NUM_BOUNDS-1:0][BOUND_W-1:0] b);
    request_t r;
    r = random_request();
    r.op   = op;
    r.slot = SLOT_W'(slot);
    r.cand = cand;
    r.bnd  = b;
    send_request(r);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int sel;
    sel = $urandom_range(99);
    if (sel < 85) return SIZE_W'($urandom_range(0, 320));
    if (sel < 95) return SIZE_W'($urandom);
    return sel[0] ? SIZE_MAX : '0;
  endfunction

  function automatic logic [BOUND_W-1:0] pick_bound();
    int sel;
    sel = $urandom_range(99);
    if (sel < 25) return WILD;
    if (sel < 85) return $urandom_range(0, 320);
    if (sel < 93) return $urandom;
    return sel[0] ? INT_MAX_B : INT_MIN_B;
  endfunction

  // mostly queries and rule writes over a small size range so rules really hit
  function automatic request_t random_traffic_item();
    request_t r;
    int sel;
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
    r = random_request();
    sel = $urandom_range(99);
    if (sel < 40) begin
      r.op = OP_QUERY;
      r.m  = pick_size();
      r.k  = pick_size();
      r.n  = pick_size();
    end else if (sel < 78) begin
      r.op   = OP_WRITE;
      r.slot = SLOT_W'($urandom_range(NUM_SLOTS - 1));
      for (int d = 0; d < 3; d++) begin
        lo = pick_bound();
        hi = pick_bound();
        // most windows come out ordered, a few stay inverted and never match
        if (hi != WILD && $signed(lo) > $signed(hi) && $urandom_range(3) != 0) begin
          r.bnd[2*d]   = hi;
          r.bnd[2*d+1] = lo;
        end else begin
          r.bnd[2*d]   = lo;
          r.bnd[2*d+1] = hi;
        end
      end
      if (r.slot < RULES_PER_TABLE && $urandom_range(2) == 0) r.cand = BIG_M_TILE;
    end else if (sel < 86) begin
      r.op   = OP_INVAL;
      r.slot = SLOT_W'($urandom_range(NUM_SLOTS - 1));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_empty_tables();
    send_query('0, '0, '0);
    send_query(SIZE_MAX, SIZE_MAX, SIZE_MAX);
  endtask

  task automatic test_default_registers();
    wait_block_idle();
    program_defaults({NUM_TABLES{16'hFFFF}});
    send_query(SIZE_MAX, '0, SIZE_MAX);
    wait_block_idle();
    program_defaults({16'h8001, 16'h0001, 16'hFFFF, 16'h0000, BIG_M_TILE});
    send_query('0, SIZE_MAX, '0);
  endtask

  task automatic test_rule_ranges();
    // catch-all rules at the lowest priority of every table
    for (int t = 0; t < NUM_TABLES; t++)
      send_rule_op(OP_WRITE, t * RULES_PER_TABLE + RULES_PER_TABLE - 1,
                   CATCH_ALL_CAND[t], ALL_WILD);
    send_query(SIZE_MAX, SIZE_MAX, SIZE_MAX);
    // single-point m window, n open up to the largest bound
    send_rule_op(OP_WRITE, TBL_M_TILE * RULES_PER_TABLE, 16'd7,
                 {INT_MAX_B, 32'd0, WILD, WILD, 32'd100, 32'd100});
    send_query(31'd100, 31'd5, 31'd0);
    send_query(31'd101, 31'd5, SIZE_MAX);
    // a lower bound below the wildcard always passes, an upper one never does
    send_rule_op(OP_WRITE, TBL_INTERVAL * RULES_PER_TABLE, 16'd9,
                 {WILD, WILD, WILD, WILD, WILD, INT_MIN_B});
    send_rule_op(OP_WRITE, TBL_TILE_ROWS * RULES_PER_TABLE, 16'd11,
                 {WILD, WILD, WILD, WILD, 32'hFFFF_FFFE, WILD});
    send_query('0, '0, '0);
    // first valid slot wins, invalidation falls through to the next one
    send_rule_op(OP_WRITE, TBL_NPU_SPLIT * RULES_PER_TABLE + 1, 16'd21, ALL_WILD);
    send_rule_op(OP_WRITE, TBL_NPU_SPLIT * RULES_PER_TABLE, 16'd20, ALL_WILD);
    send_query(31'd7, 31'd7, 31'd7);
    send_rule_op(OP_INVAL, TBL_NPU_SPLIT * RULES_PER_TABLE, 16'd0, ALL_WILD);
    send_rule_op(OP_INVAL, TBL_M_TILE * RULES_PER_TABLE + RULES_PER_TABLE - 1, 16'd0,
                 ALL_WILD);
    send_query(31'd7, 31'd7, 31'd7);
    // slots past the last table and the unused opcode leave the tables alone
    send_rule_op(OP_WRITE, NUM_SLOTS, 16'h5555, ALL_WILD);
    send_rule_op(OP_WRITE, (1 << SLOT_W) - 1, 16'h5555, ALL_WILD);
    send_rule_op(OP_UNUSED, TBL_DATA_SPLIT * RULES_PER_TABLE, 16'h5555, ALL_WILD);
    send_query(31'd100, 31'd5, 31'd0);
  endtask

  task automatic test_result_backpressure();
    wait_block_idle();
    rx_hold_req = 1'b1;
    repeat (12) send_query(pick_size(), pick_size(), pick_size());
    wait_block_idle();
  endtask

  task automatic test_random_traffic();
    request_t r;
    int useful;
    logic [NUM_TABLES-1:0][CAND_W-1:0] dv;
    for (int phase = 0; phase < 4; phase++) begin
      wait_block_idle();
      for (int t = 0; t < NUM_TABLES; t++) dv[t] = CAND_W'($urandom);
      if ($urandom_range(3) == 0) dv[TBL_M_TILE] = BIG_M_TILE;
      program_defaults(dv);
      calm = (phase == 1);
      useful = 0;
      while (useful < RANDOM_PER_PHASE) begin
        r = random_traffic_item();
        send_request(r);
        if (r.op != OP_UNUSED && (r.op == OP_QUERY || r.slot < NUM_SLOTS)) useful++;
      end
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 38);
      end
    end
  end

  function automatic void check_field(string name, logic [ROWS_W-1:0] want,
                                      logic [ROWS_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid_o === 1'b1 && m_axis_tready) begin
      if (tiling_q.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, got %h", $time,
                 m_axis_tdata_o);
        fail_count++;
      end else begin
        want_tiling = tiling_q.pop_front();
        got_tiling  = tiling_t'(m_axis_tdata_o[$bits(tiling_t)-1:0]);
        check_field("m_tile", ROWS_W'(want_tiling.m_tile),
                    ROWS_W'(got_tiling.m_tile));
        check_field("comm_interval", ROWS_W'(want_tiling.comm_interval),
                    ROWS_W'(got_tiling.comm_interval));
        check_field("comm_tile_rows",  want_tiling.tile_rows,     got_tiling.tile_rows);
        check_field("npu_split", ROWS_W'(want_tiling.npu_split),
                    ROWS_W'(got_tiling.npu_split));
        check_field("data_split", ROWS_W'(want_tiling.data_split),
                    ROWS_W'(got_tiling.data_split));
        check_field("comm_block_rows", want_tiling.block_rows,    got_tiling.block_rows);
        check_field("n_tile", ROWS_W'(want_tiling.n_tile), ROWS_W'(got_tiling.n_tile));
        check_field("k_tile", ROWS_W'(want_tiling.k_tile), ROWS_W'(got_tiling.k_tile));
      end
    end
  end

  // ends the run once no transaction has moved for too long
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready_o === 1'b1) ||
          (m_axis_tvalid_o === 1'b1 && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_wdata     <= '0;
    calm        = 1'b0;
    rx_hold_req = 1'b0;
    fail_count  = 0;
    foreach (rule_on[i]) rule_on[i] = 1'b0;
    foreach (dflt[i]) dflt[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_tables();
    test_default_registers();
    test_rule_ranges();
    test_result_backpressure();
    test_random_traffic();
    wait_block_idle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_cell.sv
hw/rtl/rrts_out.sv
hw/rtl/range_rule_tiling_selector_top.sv
sim/tb_top.sv
